>>> rtl/core/krr_pkg.sv
package krr_pkg;

  // Key field and frame store geometry
  localparam int NUM_KEYS     = 20;
  localparam int KEY_W        = 20;
  localparam int RECORD_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(RECORD_DEPTH);
  localparam int CNT_W        = $clog2(RECORD_DEPTH + 1);
  localparam int LIMIT_W      = 13;
  localparam int MODE_W       = 2;
  localparam int DIR_W        = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << NUM_KEYS) - 64'd1);

  // Mode register codes; the unused code behaves as live
  localparam logic [MODE_W-1:0] MODE_LIVE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPLAY = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 1'd1;

  // Key bit positions
  localparam int BIT_W = 0;
  localparam int BIT_S = 1;
  localparam int BIT_A = 2;
  localparam int BIT_D = 3;
  localparam int BIT_E = 6;
  localparam int BIT_Q = 7;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_FWD   = 3'd0;
  localparam logic [DIR_W-1:0] DIR_BACK  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_RT    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LT    = 3'd3;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd4;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd5;
  localparam logic [DIR_W-1:0] DIR2_NONE = 3'd4;
  localparam logic [DIR_W-1:0] DIR3_NONE = 3'd6;

  // Item waiting for its frame store read
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             replay;
    logic [KEY_W-1:0] keys;
  } stage_t;

  // One result beat
  typedef struct packed {
    logic             replaying;
    logic [DIR_W-1:0] dir3_press;
    logic [DIR_W-1:0] dir3_trigger;
    logic [DIR_W-1:0] dir_press;
    logic [DIR_W-1:0] dir_trigger;
    logic [KEY_W-1:0] release_mask;
    logic [KEY_W-1:0] trigger_mask;
    logic [KEY_W-1:0] pressed_mask;
  } result_t;

  // First key in W, S, D, A order wins
  function automatic logic [DIR_W-1:0] dir2(input logic [KEY_W-1:0] m);
    logic [DIR_W-1:0] d;
    d = DIR2_NONE;
    if (m[BIT_A]) d = DIR_LT;
    if (m[BIT_D]) d = DIR_RT;
    if (m[BIT_S]) d = DIR_BACK;
    if (m[BIT_W]) d = DIR_FWD;
    return d;
  endfunction

  // First key in W, S, D, A, E, Q order wins
  function automatic logic [DIR_W-1:0] dir3(input logic [KEY_W-1:0] m);
    logic [DIR_W-1:0] d;
    d = DIR3_NONE;
    if (m[BIT_Q]) d = DIR_DOWN;
    if (m[BIT_E]) d = DIR_UP;
    if (m[BIT_A]) d = DIR_LT;
    if (m[BIT_D]) d = DIR_RT;
    if (m[BIT_S]) d = DIR_BACK;
    if (m[BIT_W]) d = DIR_FWD;
    return d;
  endfunction

endpackage

>>> rtl/core/krr_frame_ram.sv
module krr_frame_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/krr_ctrl.sv
module krr_ctrl
  import krr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_accept,
  input  logic [KEY_W-1:0]      in_keys,
  input  logic                  s1_adv,
  output stage_t                s1,
  output logic                  ram_we,
  output logic [ADDR_W-1:0]     ram_waddr,
  output logic [KEY_W-1:0]      ram_wdata,
  output logic                  ram_re,
  output logic [ADDR_W-1:0]     ram_raddr
);

  logic [MODE_W-1:0]  mode_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   rec_cnt_r;
  logic [CNT_W-1:0]   rep_pos_r;
  stage_t             s1_r;
  stage_t             s1_nxt;
  logic [CNT_W-1:0]   limit_cap;
  logic               rec_ok;
  logic               rep_hit;
  logic               is_replay;
  logic [KEY_W-1:0]   keys_m;

  // Cap the frame limit at the store depth
  assign limit_cap = (32'(limit_r) > 32'(RECORD_DEPTH)) ? CNT_W'(RECORD_DEPTH)
                                                         : CNT_W'(limit_r);

  assign is_replay = (mode_r == MODE_REPLAY);
  assign rec_ok    = (mode_r == MODE_RECORD) && (rec_cnt_r < limit_cap);
  assign rep_hit   = is_replay && (rep_pos_r < rec_cnt_r);
  assign keys_m    = in_keys & KEY_MASK;

  // Frame store access for the accepted beat
  assign ram_we    = in_accept && rec_ok;
  assign ram_waddr = rec_cnt_r[ADDR_W-1:0];
  assign ram_wdata = keys_m;
  assign ram_re    = in_accept;
  assign ram_raddr = rep_pos_r[ADDR_W-1:0];

  // Load the read stage on accept, drop it when it moves on
  always_comb begin
    s1_nxt = s1_r;
    if (in_accept) begin
      s1_nxt.valid  = 1'b1;
      s1_nxt.hit    = rep_hit;
      s1_nxt.replay = is_replay;
      s1_nxt.keys   = keys_m;
    end else if (s1_adv) begin
      s1_nxt.valid = 1'b0;
    end
  end

  // Registers, counters and stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_LIVE;
      limit_r      <= '0;
      rec_cnt_r    <= '0;
      rep_pos_r    <= '0;
      s1_r.valid   <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE: begin
            mode_r <= cfg_wdata[MODE_W-1:0];
            if (cfg_wdata[MODE_W-1:0] == MODE_RECORD) rec_cnt_r <= '0;
            if (cfg_wdata[MODE_W-1:0] == MODE_REPLAY) rep_pos_r <= '0;
          end
          REG_FRAME_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end else if (in_accept) begin
        if (rec_ok)  rec_cnt_r <= rec_cnt_r + CNT_W'(1);
        if (rep_hit) rep_pos_r <= rep_pos_r + CNT_W'(1);
      end
    end
  end

  assign s1 = s1_r;

endmodule

>>> rtl/core/krr_edge.sv
module krr_edge
  import krr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  stage_t           s1,
  input  logic [KEY_W-1:0] rd_data,
  input  logic             out_ready,
  output logic             s1_adv,
  output logic             out_valid,
  output result_t          res
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [KEY_W-1:0] last_keys_r;
  result_t          res_r;
  result_t          res_nxt;
  logic [KEY_W-1:0] cur;
  logic [KEY_W-1:0] trig;
  logic [KEY_W-1:0] rel;

  // Advance when the output register is free or being drained
  assign s1_adv = s1.valid && (!out_valid_r || out_ready);

  // Pick the mask used this frame
  always_comb begin
    if (s1.hit) begin
      cur = rd_data & KEY_MASK;
    end else if (s1.replay) begin
      cur = '0;
    end else begin
      cur = s1.keys;
    end
  end

  assign trig = (last_keys_r ^ cur) & cur;
  assign rel  = (last_keys_r ^ cur) & last_keys_r;

  // Build the result beat
  always_comb begin
    res_nxt.pressed_mask = cur;
    res_nxt.trigger_mask = trig;
    res_nxt.release_mask = rel;
    res_nxt.dir_trigger  = dir2(trig);
    res_nxt.dir_press    = dir2(cur);
    res_nxt.dir3_trigger = dir3(trig);
    res_nxt.dir3_press   = dir3(cur);
    res_nxt.replaying    = s1.replay;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold previous frame and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_keys_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        last_keys_r <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

>>> rtl/core/key_record_replay_edge_detect_unit.sv
// Channel | Bus                    | Contents (lowest bit first)
// in      | in_tvalid/tready/tdata | live_keys[19:0], zero pad to 24 bits
// out     | out_tvalid/tready/tdata| pressed, trigger, release masks, dir_trigger,
//         |                        | dir_press, dir3_trigger, dir3_press, replaying
// cfg     | cfg_we/index/wdata     | 0 mode, 1 frame_limit
//
// One beat per cycle sustained unless the output stalls; a result passes the read
// stage and then the output register. The rate is set by the frame store's single
// read and single write port, one access each per beat, with registered read data.
// Reset is synchronous on rst_n low; the frame store is not cleared.
// A stalled output holds its beat while one more input beat is taken.
module key_record_replay_edge_detect_unit
  import krr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // live_keys[19:0], pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [79:0]           out_tdata,  // pressed_mask[19:0], trigger_mask[39:20],
                                            // release_mask[59:40], dir_trigger[62:60],
                                            // dir_press[65:63], dir3_trigger[68:66],
                                            // dir3_press[71:69], replaying[72], pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RES_W = $bits(result_t);

  stage_t            s1;
  logic              s1_adv;
  logic              in_accept;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;
  result_t           res;

  // Take a beat whenever the read stage is empty or moving on
  assign in_tready = !s1.valid || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  krr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .in_keys   (in_tdata[KEY_W-1:0]),
    .s1_adv    (s1_adv),
    .s1        (s1),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  krr_frame_ram #(
    .DEPTH (RECORD_DEPTH),
    .WIDTH (KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  krr_edge u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1        (s1),
    .rd_data   (ram_rdata),
    .out_ready (out_tready),
    .s1_adv    (s1_adv),
    .out_valid (out_tvalid),
    .res       (res)
  );

  assign out_tdata = {(80 - RES_W)'(0), res};

  // Empty output register never blocks the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Newly pressed and newly released keys never overlap
  a_trig_rel_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((res.trigger_mask & res.release_mask) == '0))
    else $error("trigger and release overlap");

  // Triggers are a subset of the pressed keys
  a_trig_in_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((res.trigger_mask & ~res.pressed_mask) == '0))
    else $error("trigger outside pressed mask");

  // Released keys are not pressed
  a_rel_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((res.release_mask & res.pressed_mask) == '0))
    else $error("released key still pressed");

endmodule
